// ===== design/bchd_pkg.sv =====
// Package for the button click/hold detector.
// Holds the phase and event codes, the field widths and the structs passed between modules.
// No dependencies.
package bchd_pkg;

    localparam int LEVEL_W = 8;
    localparam int TICK_W  = 16;
    localparam int CLICK_W = 8;
    localparam int PHASE_W = 3;
    localparam int EVENT_W = 3;
    localparam int BTN_W   = 3;

    localparam logic [TICK_W-1:0]  TICK_MAX  = '1;
    localparam logic [CLICK_W-1:0] CLICK_MAX = '1;
    localparam logic [CLICK_W-1:0] CLICK_ONE = CLICK_W'(1);

    // Register indexes on the configuration channel
    localparam logic CFG_HOLD_TICKS   = 1'b0;
    localparam logic CFG_CLICK_WINDOW = 1'b1;

    // Input item kinds
    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_WAKE = 1'b1;

    // Per-button phase codes
    localparam logic [PHASE_W-1:0] PH_IDLE     = 3'd0;
    localparam logic [PHASE_W-1:0] PH_UNSTABLE = 3'd1;
    localparam logic [PHASE_W-1:0] PH_STABLE   = 3'd2;
    localparam logic [PHASE_W-1:0] PH_WAIT_REL = 3'd3;
    localparam logic [PHASE_W-1:0] PH_WAIT_NXT = 3'd4;

    // Event codes
    localparam logic [EVENT_W-1:0] EV_PRESS   = 3'd0;
    localparam logic [EVENT_W-1:0] EV_REPEAT  = 3'd1;
    localparam logic [EVENT_W-1:0] EV_RELEASE = 3'd2;
    localparam logic [EVENT_W-1:0] EV_HOLD    = 3'd3;
    localparam logic [EVENT_W-1:0] EV_MCLICK  = 3'd4;

    // One result item without its last flag
    typedef struct packed {
        logic [BTN_W-1:0]   btn;
        logic [EVENT_W-1:0] ev;
        logic [CLICK_W-1:0] clicks;
    } t_res;

    // Outcome of one button step
    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [TICK_W-1:0]  tick;
        logic [CLICK_W-1:0] click;
        logic               clear;
        logic               ev0_vld;
        logic [EVENT_W-1:0] ev0;
        logic [CLICK_W-1:0] ev0_clicks;
        logic               ev1_vld;
        logic [CLICK_W-1:0] ev1_clicks;
    } t_step;

    // Commands to the button state store
    typedef struct packed {
        logic wr;
        logic clr;
        logic wake;
    } t_store_cmd;

endpackage

// ===== design/bchd_step.sv =====
// Shared per-button step unit of the button click/hold detector.
// Computes one button's next phase, counts and events for a tick.
// Depends on bchd_pkg.
module bchd_step (
    input  logic [bchd_pkg::PHASE_W-1:0] i_phase,
    input  logic [bchd_pkg::TICK_W-1:0]  i_tick,
    input  logic [bchd_pkg::CLICK_W-1:0] i_click,
    input  logic                         i_down,
    input  logic [bchd_pkg::TICK_W-1:0]  i_hold_ticks,
    input  logic [bchd_pkg::TICK_W-1:0]  i_click_window,
    output bchd_pkg::t_step              o_step
);
    import bchd_pkg::*;

    logic [TICK_W-1:0]  w_tick;
    logic [CLICK_W-1:0] w_click_inc;

    // Count the tick for any non-idle button, saturating
    assign w_tick = (i_phase != PH_IDLE && i_tick != TICK_MAX) ? i_tick + TICK_W'(1) : i_tick;
    assign w_click_inc = (i_click != CLICK_MAX) ? i_click + CLICK_ONE : i_click;

    // Advance the button's phase machine
    always_comb begin
        o_step            = '0;
        o_step.phase      = i_phase;
        o_step.tick       = w_tick;
        o_step.click      = i_click;
        o_step.ev0_clicks = i_click;
        o_step.ev1_clicks = w_click_inc;
        unique case (i_phase)
            PH_IDLE: begin
                if (i_down) begin
                    o_step.phase = PH_UNSTABLE;
                end
            end
            PH_UNSTABLE: begin
                if (i_down) begin
                    o_step.ev0_vld = 1'b1;
                    o_step.ev0     = EV_PRESS;
                    o_step.phase   = PH_STABLE;
                    o_step.click   = w_click_inc;
                    o_step.ev1_vld = (w_click_inc > CLICK_ONE);
                end else if (i_click == '0) begin
                    o_step.clear = 1'b1;
                end else begin
                    o_step.phase = PH_WAIT_NXT;
                end
            end
            PH_STABLE: begin
                if (!i_down) begin
                    o_step.ev0_vld = 1'b1;
                    o_step.ev0     = EV_RELEASE;
                    o_step.phase   = PH_WAIT_NXT;
                end else if (w_tick > i_hold_ticks) begin
                    o_step.ev0_vld = 1'b1;
                    o_step.ev0     = EV_HOLD;
                    o_step.phase   = PH_WAIT_REL;
                end
            end
            PH_WAIT_REL: begin
                if (!i_down) begin
                    o_step.ev0_vld = 1'b1;
                    o_step.ev0     = EV_RELEASE;
                    o_step.clear   = 1'b1;
                end
            end
            PH_WAIT_NXT: begin
                if (w_tick > i_click_window) begin
                    o_step.ev0_vld = 1'b1;
                    o_step.ev0     = EV_MCLICK;
                    o_step.clear   = 1'b1;
                end else begin
                    o_step.phase = PH_UNSTABLE;
                end
            end
            default: begin
                // Unreachable codes: only the tick is counted
            end
        endcase
    end

endmodule

// ===== design/bchd_store.sv =====
// Per-button state store of the button click/hold detector.
// Holds phase, tick count and click count for each button; one write port, clear-all and wake.
// Depends on bchd_pkg.
module bchd_store #(
    parameter int BUTTONS = 8,
    parameter int IDX_W   = 3
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bchd_pkg::t_store_cmd         i_cmd,
    input  logic [IDX_W-1:0]             i_idx,
    input  logic [BUTTONS-1:0]           i_wake_mask,
    input  logic [bchd_pkg::PHASE_W-1:0] i_phase,
    input  logic [bchd_pkg::TICK_W-1:0]  i_tick,
    input  logic [bchd_pkg::CLICK_W-1:0] i_click,
    output logic [bchd_pkg::PHASE_W-1:0] o_phase,
    output logic [bchd_pkg::TICK_W-1:0]  o_tick,
    output logic [bchd_pkg::CLICK_W-1:0] o_click
);
    import bchd_pkg::*;

    logic [PHASE_W-1:0] r_phase [BUTTONS];
    logic [TICK_W-1:0]  r_tick  [BUTTONS];
    logic [CLICK_W-1:0] r_click [BUTTONS];

    // Read the button under the walk
    assign o_phase = r_phase[i_idx];
    assign o_tick  = r_tick[i_idx];
    assign o_click = r_click[i_idx];

    // Clear all, arm pressed buttons on wake, or write back one button
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < BUTTONS; j++) begin
            if (!i_rst_n || i_cmd.clr) begin
                r_phase[j] <= PH_IDLE;
                r_tick[j]  <= '0;
                r_click[j] <= '0;
            end else if (i_cmd.wake) begin
                if (i_wake_mask[j]) begin
                    r_phase[j] <= PH_UNSTABLE;
                    r_tick[j]  <= '0;
                    r_click[j] <= '0;
                end
            end else if (i_cmd.wr && i_idx == IDX_W'(j)) begin
                r_phase[j] <= i_phase;
                r_tick[j]  <= i_tick;
                r_click[j] <= i_click;
            end
        end
    end

endmodule

// ===== design/button_click_hold_detector.sv =====
// Top level of the button click/hold detector: sequencer, config registers, result output.
// Walks the buttons through the shared step unit; depends on bchd_pkg, bchd_step, bchd_store.
//
//  channel  | dir | handshake              | payload
//  ---------+-----+------------------------+---------------------------------------------
//  s (in)   | in  | i_s_tvalid/o_s_tready  | tdata: levels; tuser: kind
//  m (out)  | out | o_m_tvalid/i_m_tready  | tdata: button, clicks; tuser: event_res; tlast
//  cfg      | in  | i_cfg_valid/o_cfg_ready| i_cfg_index, i_cfg_data
//
// A wake request is taken while idle and arms the pressed buttons. A tick request walks each
// button through the shared step unit, with an extra step for each repeated press and a flush of
// the last result; the step unit is the only datapath. Results pass through a pending
// register and an output register; the walk stalls only when both are full.
// Reset is synchronous, active low, and clears all button state and restores the registers.
module button_click_hold_detector #(
    parameter int BUTTONS = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [7:0]                   i_s_tdata,   // [7:0] levels
    input  logic [0:0]                   i_s_tuser,   // [0] kind
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [15:0]                  o_m_tdata,   // [2:0] button, [10:3] clicks, [15:11] 0
    output logic [2:0]                   o_m_tuser,   // [2:0] event_res
    output logic                         o_m_tlast,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [0:0]                   i_cfg_index,
    input  logic [bchd_pkg::TICK_W-1:0]  i_cfg_data
);
    import bchd_pkg::*;

    localparam int IDX_W = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(BUTTONS - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WALK  = 2'd1;
    localparam logic [1:0] ST_EMIT2 = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;

    logic [1:0]         r_state, n_state;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [LEVEL_W-1:0] r_lv, n_lv;
    logic [TICK_W-1:0]  r_hold, n_hold;
    logic [TICK_W-1:0]  r_window, n_window;
    t_res               r_pend, n_pend;
    logic               r_pend_vld, n_pend_vld;
    t_res               r_ev1, n_ev1;
    t_res               r_out, n_out;
    logic               r_out_vld, n_out_vld;
    logic               r_out_last, n_out_last;

    logic [BUTTONS-1:0] w_lv;
    logic [BUTTONS-1:0] w_wake_mask;
    logic [BTN_W-1:0]   w_btn;
    logic [PHASE_W-1:0] w_phase;
    logic [TICK_W-1:0]  w_tick;
    logic [CLICK_W-1:0] w_click;
    t_step              w_step;
    t_store_cmd         w_cmd;
    t_res               w_push_res;
    logic               w_push;
    logic               w_stall;
    logic               w_out_free;
    logic               w_flush_ld;
    logic               w_accept;

    // Spread the level bits over the buttons; buttons past the field read released
    for (genvar j = 0; j < BUTTONS; j++) begin : g_lv
        if (j < LEVEL_W) begin : g_on
            assign w_lv[j]        = r_lv[j];
            assign w_wake_mask[j] = i_s_tdata[j];
        end else begin : g_off
            assign w_lv[j]        = 1'b0;
            assign w_wake_mask[j] = 1'b0;
        end
    end

    assign w_btn      = BTN_W'(r_idx);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_vld || i_m_tready;

    bchd_store #(
        .BUTTONS (BUTTONS),
        .IDX_W   (IDX_W)
    ) u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_idx       (r_idx),
        .i_wake_mask (w_wake_mask),
        .i_phase     (w_step.phase),
        .i_tick      (w_step.tick),
        .i_click     (w_step.click),
        .o_phase     (w_phase),
        .o_tick      (w_tick),
        .o_click     (w_click)
    );

    bchd_step u_step (
        .i_phase        (w_phase),
        .i_tick         (w_tick),
        .i_click        (w_click),
        .i_down         (w_lv[r_idx]),
        .i_hold_ticks   (r_hold),
        .i_click_window (r_window),
        .o_step         (w_step)
    );

    // Pick the result to push into the pending register this cycle
    always_comb begin
        w_push     = 1'b0;
        w_push_res = r_ev1;
        if (r_state == ST_WALK) begin
            w_push     = w_step.ev0_vld;
            w_push_res = '{btn: w_btn, ev: w_step.ev0, clicks: w_step.ev0_clicks};
        end else if (r_state == ST_EMIT2) begin
            w_push = 1'b1;
        end
    end

    // Hold the walk while a push would overrun both result registers
    assign w_stall    = w_push && r_pend_vld && !w_out_free;
    assign w_flush_ld = (r_state == ST_FLUSH) && r_pend_vld && w_out_free;

    // Store commands: wake on an accepted wake, write back and clear on a walk step
    always_comb begin
        w_cmd      = '0;
        w_cmd.wake = w_accept && (i_s_tuser[0] == KIND_WAKE);
        w_cmd.wr   = (r_state == ST_WALK) && !w_stall;
        w_cmd.clr  = (r_state == ST_WALK) && !w_stall && w_step.clear;
    end

    // Sequencer, pending and output registers
    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_lv       = r_lv;
        n_ev1      = r_ev1;
        n_pend     = r_pend;
        n_pend_vld = r_pend_vld;
        n_out      = r_out;
        n_out_last = r_out_last;
        n_out_vld  = r_out_vld && !i_m_tready;
        n_hold     = r_hold;
        n_window   = r_window;

        if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index[0])
                CFG_HOLD_TICKS:   n_hold   = i_cfg_data;
                CFG_CLICK_WINDOW: n_window = i_cfg_data;
                default:          n_hold   = r_hold;
            endcase
        end

        // Move the pending result out when a new one replaces it
        if (w_push && !w_stall) begin
            if (r_pend_vld) begin
                n_out      = r_pend;
                n_out_last = 1'b0;
                n_out_vld  = 1'b1;
            end
            n_pend     = w_push_res;
            n_pend_vld = 1'b1;
        end
        // The final result of a request carries last
        if (w_flush_ld) begin
            n_out      = r_pend;
            n_out_last = 1'b1;
            n_out_vld  = 1'b1;
            n_pend_vld = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && i_s_tuser[0] == KIND_TICK) begin
                    n_state = ST_WALK;
                    n_idx   = '0;
                    n_lv    = i_s_tdata;
                end
            end
            ST_WALK: begin
                if (!w_stall) begin
                    if (w_step.ev1_vld) begin
                        n_ev1   = '{btn: w_btn, ev: EV_REPEAT, clicks: w_step.ev1_clicks};
                        n_state = ST_EMIT2;
                    end else if (r_idx == IDX_LAST) begin
                        n_state = ST_FLUSH;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end
            ST_EMIT2: begin
                if (!w_stall) begin
                    if (r_idx == IDX_LAST) begin
                        n_state = ST_FLUSH;
                    end else begin
                        n_idx   = r_idx + IDX_W'(1);
                        n_state = ST_WALK;
                    end
                end
            end
            ST_FLUSH: begin
                if (!r_pend_vld || w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_idx      <= '0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
            r_hold     <= TICK_W'(100);
            r_window   <= TICK_W'(50);
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
            r_hold     <= n_hold;
            r_window   <= n_window;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_lv       <= n_lv;
        r_ev1      <= n_ev1;
        r_pend     <= n_pend;
        r_out      <= n_out;
        r_out_last <= n_out_last;
    end

    assign o_s_tready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_vld;
    assign o_m_tdata   = {5'b0, r_out.clicks, r_out.btn};
    assign o_m_tuser   = r_out.ev;
    assign o_m_tlast   = r_out_last;

`ifndef NO_ASSERTIONS
    // No result may linger in the pending register once a request is done
    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_pend_vld)
        else $error("pending result left behind at idle");

    // The repeated press always follows a press that sits in the pending register
    a_emit2_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT2) |-> (r_pend_vld && r_pend.ev == EV_PRESS))
        else $error("repeated press without a pending press");

    // A flush that can move its result finishes the request
    a_flush_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FLUSH && (!r_pend_vld || w_out_free)) |=> (r_state == ST_IDLE))
        else $error("flush did not complete");

    // The walk index stays within the button range
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK || r_state == ST_EMIT2) |-> (r_idx <= IDX_LAST))
        else $error("walk index out of range");
`endif

endmodule
